FILE: hdl/pfrf_pkg.sv
// Shared types and constants of the page framebuffer rectangle fill block.
package pfrf_pkg;

  localparam int CW          = 12;   // internal signed coordinate width
  localparam int COORD_W     = 11;
  localparam int MODE_W      = 2;
  localparam int RD_COL_W    = 7;
  localparam int RD_PAGE_W   = 3;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 16;
  localparam int CFG_DATA_W  = 8;
  localparam int CFG_IDX_W   = 2;

  localparam logic [7:0] BYTE_ONES = 8'hff;
  localparam logic [2:0] BIT_TOP   = 3'd7;

  localparam logic [7:0] CLIP_LEFT_RST   = 8'd0;
  localparam logic [6:0] CLIP_TOP_RST    = 7'd0;
  localparam logic [7:0] CLIP_RIGHT_RST  = 8'd128;
  localparam logic [6:0] CLIP_BOTTOM_RST = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CLIP_LEFT   = 2'd0,
    CFG_CLIP_TOP    = 2'd1,
    CFG_CLIP_RIGHT  = 2'd2,
    CFG_CLIP_BOTTOM = 2'd3
  } cfg_idx_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_SET    = 2'd0,
    MODE_CLEAR  = 2'd1,
    MODE_INVERT = 2'd2
  } paint_mode_t;

  localparam logic OP_FILL = 1'b0;
  localparam logic OP_READ = 1'b1;

  typedef struct packed {
    logic [7:0] left;
    logic [6:0] top;
    logic [7:0] right;
    logic [6:0] bottom;
  } clip_t;

  typedef struct packed {
    logic load;
    logic sort;
    logic clamp;
    logic check;
    logic walk;
    logic rd_addr;
    logic rd_capture;
    logic load_out;
  } dp_cmd_t;

  typedef struct packed {
    logic clearing;
    logic empty;
    logic col_last;
    logic page_last;
    logic out_full;
  } dp_status_t;

endpackage

FILE: hdl/page_framebuffer_rect_fill.sv
// Top level of the page framebuffer rectangle fill: ports, clip registers, controller and datapath.
// A fill is sorted, clamped and checked, then walks its bytes, modifying one byte per cycle
// through the frame store's read and write ports; an empty fill skips the walk. A read sets
// the address, waits for the registered read port and captures the byte. One item is in work
// at a time; the next is taken as soon as the result sits in the output register. After reset
// the frame store is cleared while in_tready stays low; clip registers reset.
module page_framebuffer_rect_fill
  import pfrf_pkg::*;
#(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // corner_x_a, corner_y_a, corner_x_b, corner_y_b, paint_mode, read_column, read_page
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // operation
  input  logic                   in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // read_byte, clipped_away
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wr_data
);

  clip_t      clip_r;
  dp_cmd_t    cmd;
  dp_status_t status;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clip_r.left   <= CLIP_LEFT_RST;
      clip_r.top    <= CLIP_TOP_RST;
      clip_r.right  <= CLIP_RIGHT_RST;
      clip_r.bottom <= CLIP_BOTTOM_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_CLIP_LEFT:   clip_r.left   <= cfg_wr_data;
        CFG_CLIP_TOP:    clip_r.top    <= cfg_wr_data[6:0];
        CFG_CLIP_RIGHT:  clip_r.right  <= cfg_wr_data;
        CFG_CLIP_BOTTOM: clip_r.bottom <= cfg_wr_data[6:0];
        default: ;
      endcase
    end
  end

  pfrf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_op     (in_tuser),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  pfrf_datapath #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .status     (status),
    .clip       (clip_r),
    .in_tdata   (in_tdata),
    .out_tready (out_tready),
    .out_tvalid (out_tvalid),
    .out_tdata  (out_tdata)
  );

endmodule

FILE: hdl/pfrf_ctrl.sv
// Controller state machine that sequences fills, reads and result hand-off.
module pfrf_ctrl
  import pfrf_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_op,
  output logic       in_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_CLAMP,
    ST_CHECK,
    ST_WALK,
    ST_DRAIN,
    ST_RD_ADDR,
    ST_RD_WAIT,
    ST_RD_DATA,
    ST_RESULT
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_tready = (state_r == ST_IDLE) && !status.clearing;
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = accept;
        if (accept) begin
          state_nxt = (in_op == OP_READ) ? ST_RD_ADDR : ST_SORT;
        end
      end
      ST_SORT: begin
        cmd.sort  = 1'b1;
        state_nxt = ST_CLAMP;
      end
      ST_CLAMP: begin
        cmd.clamp = 1'b1;
        state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        cmd.check = 1'b1;
        state_nxt = status.empty ? ST_RESULT : ST_WALK;
      end
      ST_WALK: begin
        cmd.walk = 1'b1;
        if (status.col_last && status.page_last) begin
          state_nxt = ST_DRAIN;
        end
      end
      // The last byte of the walk is written back in this cycle.
      ST_DRAIN: begin
        state_nxt = ST_RESULT;
      end
      ST_RD_ADDR: begin
        cmd.rd_addr = 1'b1;
        state_nxt   = ST_RD_WAIT;
      end
      ST_RD_WAIT: begin
        state_nxt = ST_RD_DATA;
      end
      ST_RD_DATA: begin
        cmd.rd_capture = 1'b1;
        state_nxt      = ST_RESULT;
      end
      ST_RESULT: begin
        if (!status.out_full) begin
          cmd.load_out = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/pfrf_datapath.sv
// Datapath: rectangle clamping, page and column walk, frame store and result registers.
module pfrf_datapath
  import pfrf_pkg::*;
#(
  parameter int WIDTH  = 128,
  parameter int HEIGHT = 64
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  output dp_status_t             status,
  input  clip_t                  clip,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tready,
  output logic                   out_tvalid,
  output logic [OUT_TDATA_W-1:0] out_tdata
);

  localparam int PAGES      = (HEIGHT + 7) / 8;
  localparam int STORE_SIZE = WIDTH * PAGES;
  localparam int AW         = $clog2(STORE_SIZE);
  localparam int XW         = $clog2(WIDTH);
  localparam int YW         = $clog2(HEIGHT);
  localparam int PW         = (PAGES > 1) ? $clog2(PAGES) : 1;

  localparam logic [AW-1:0]        WIDTH_A = AW'(WIDTH);
  localparam logic [AW-1:0]        LAST_A  = AW'(STORE_SIZE - 1);
  localparam logic signed [CW-1:0] WIDTH_S = CW'(WIDTH);
  localparam logic signed [CW-1:0] HEIGHT_S = CW'(HEIGHT);

  // Input word fields
  logic [COORD_W-1:0]   f_xa, f_ya, f_xb, f_yb;
  logic [MODE_W-1:0]    f_mode;
  logic [RD_COL_W-1:0]  f_col;
  logic [RD_PAGE_W-1:0] f_page;

  assign f_xa   = in_tdata[10:0];
  assign f_ya   = in_tdata[21:11];
  assign f_xb   = in_tdata[32:22];
  assign f_yb   = in_tdata[43:33];
  assign f_mode = in_tdata[45:44];
  assign f_col  = in_tdata[52:46];
  assign f_page = in_tdata[55:53];

  logic signed [CW-1:0] x0_r, x1_r, y0_r, y1_r;
  logic [MODE_W-1:0]    mode_r;
  logic [RD_COL_W-1:0]  rd_col_r;
  logic [RD_PAGE_W-1:0] rd_page_r;
  logic [PW-1:0]        page_r;
  logic [XW-1:0]        col_r;
  logic [AW-1:0]        addr_r, line_start_r;
  logic                 rd_ok_r;
  logic [7:0]           rdata_r;
  logic                 wb_valid_r;
  logic [AW-1:0]        wb_addr_r;
  logic [7:0]           wb_mask_r;
  logic [7:0]           res_byte_r;
  logic                 res_empty_r;
  logic                 out_valid_r;
  logic [7:0]           out_byte_r;
  logic                 out_empty_r;
  logic                 clearing_r;
  logic [AW-1:0]        clr_cnt_r;

  logic [7:0] mem [STORE_SIZE];

  // Clip window edges as signed values, right and bottom limited to the image.
  logic signed [CW-1:0] left_s, top_s, right_s, bottom_s;
  logic signed [CW-1:0] clip_right_s, clip_bottom_s;

  assign left_s        = $signed({4'b0, clip.left});
  assign top_s         = $signed({5'b0, clip.top});
  assign clip_right_s  = $signed({4'b0, clip.right});
  assign clip_bottom_s = $signed({5'b0, clip.bottom});
  assign right_s       = (clip_right_s > WIDTH_S) ? WIDTH_S : clip_right_s;
  assign bottom_s      = (clip_bottom_s > HEIGHT_S) ? HEIGHT_S : clip_bottom_s;

  // Once the area is known to be non-empty, the corners lie inside the image.
  logic [XW-1:0] x0n, x1n;
  logic [YW-1:0] y0n, y1n;
  logic [PW-1:0] ps_c, pe_c;
  logic [AW-1:0] start_addr_c;

  assign x0n          = x0_r[XW-1:0];
  assign x1n          = x1_r[XW-1:0];
  assign y0n          = y0_r[YW-1:0];
  assign y1n          = y1_r[YW-1:0];
  assign ps_c         = PW'(y0n >> 3);
  assign pe_c         = PW'(y1n >> 3);
  assign start_addr_c = AW'(int'(ps_c) * WIDTH + int'(x0n));

  logic [2:0] lo_c, hi_c;
  logic [7:0] mask_c;

  assign lo_c   = (page_r == ps_c) ? y0n[2:0] : 3'd0;
  assign hi_c   = (page_r == pe_c) ? y1n[2:0] : BIT_TOP;
  assign mask_c = (BYTE_ONES << lo_c) & (BYTE_ONES >> (BIT_TOP - hi_c));

  logic [7:0] wb_data_c;

  always_comb begin
    unique case (mode_r)
      MODE_SET:    wb_data_c = rdata_r | wb_mask_r;
      MODE_CLEAR:  wb_data_c = rdata_r & ~wb_mask_r;
      MODE_INVERT: wb_data_c = rdata_r ^ wb_mask_r;
      default:     wb_data_c = rdata_r;
    endcase
  end

  assign status.clearing  = clearing_r;
  assign status.empty     = (x1_r < x0_r) || (y1_r < y0_r);
  assign status.col_last  = (col_r == x1n);
  assign status.page_last = (page_r == pe_c);
  assign status.out_full  = out_valid_r && !out_tready;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, out_empty_r, out_byte_r};

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x0_r      <= $signed({f_xa[COORD_W-1], f_xa});
      y0_r      <= $signed({f_ya[COORD_W-1], f_ya});
      x1_r      <= $signed({f_xb[COORD_W-1], f_xb});
      y1_r      <= $signed({f_yb[COORD_W-1], f_yb});
      mode_r    <= f_mode;
      rd_col_r  <= f_col;
      rd_page_r <= f_page;
    end else if (cmd.sort) begin
      if (x1_r < x0_r) begin
        x0_r <= x1_r;
        x1_r <= x0_r;
      end
      if (y1_r < y0_r) begin
        y0_r <= y1_r;
        y1_r <= y0_r;
      end
    end else if (cmd.clamp) begin
      if (x0_r < left_s) begin
        x0_r <= left_s;
      end
      if (x1_r >= right_s) begin
        x1_r <= right_s - CW'(1);
      end
      if (y0_r < top_s) begin
        y0_r <= top_s;
      end
      if (y1_r >= bottom_s) begin
        y1_r <= bottom_s - CW'(1);
      end
    end

    if (cmd.check) begin
      page_r       <= ps_c;
      line_start_r <= start_addr_c;
      addr_r       <= start_addr_c;
      col_r        <= x0n;
    end else if (cmd.walk) begin
      if (col_r == x1n) begin
        if (page_r != pe_c) begin
          page_r       <= page_r + 1'b1;
          line_start_r <= line_start_r + WIDTH_A;
          addr_r       <= line_start_r + WIDTH_A;
          col_r        <= x0n;
        end
      end else begin
        col_r  <= col_r + 1'b1;
        addr_r <= addr_r + 1'b1;
      end
    end else if (cmd.rd_addr) begin
      addr_r  <= AW'(int'(rd_page_r) * WIDTH + int'(rd_col_r));
      rd_ok_r <= (int'(rd_col_r) < WIDTH) && (int'(rd_page_r) < PAGES);
    end

    wb_addr_r <= addr_r;
    wb_mask_r <= mask_c;

    if (cmd.check) begin
      res_byte_r  <= 8'd0;
      res_empty_r <= status.empty;
    end else if (cmd.rd_capture) begin
      res_byte_r  <= rd_ok_r ? rdata_r : 8'd0;
      res_empty_r <= 1'b0;
    end

    if (cmd.load_out) begin
      out_byte_r  <= res_byte_r;
      out_empty_r <= res_empty_r;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wb_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      clearing_r  <= 1'b1;
      clr_cnt_r   <= '0;
    end else begin
      wb_valid_r <= cmd.walk;
      if (cmd.load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == LAST_A) begin
          clearing_r <= 1'b0;
        end
      end
    end
  end

  // Frame store: one write port shared by the clear pass and the write-back,
  // one registered read port that follows the address register.
  always_ff @(posedge clk) begin
    if (clearing_r) begin
      mem[clr_cnt_r] <= 8'd0;
    end else if (wb_valid_r) begin
      mem[wb_addr_r] <= wb_data_c;
    end
    rdata_r <= mem[addr_r];
  end

endmodule
